@@ sv/assert_macros.svh @@
// assertion helpers for the pileup counter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

@@ sv/pacsf_pkg.sv @@
package pacsf_pkg;

   localparam int NUM_SAMPLES = 16;
   localparam int COUNT_BITS  = 16;
   localparam int NUM_ALLELES = 4;
   localparam int SAMPLE_BITS = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
   localparam int ENTRY_BITS  = SAMPLE_BITS + 2;
   localparam int NUM_ENTRIES = NUM_SAMPLES * NUM_ALLELES;
   // depth of one sample fits COUNT_BITS+2, site total COUNT_BITS+3+SAMPLE_BITS
   localparam int SDEPTH_BITS = COUNT_BITS + 2;
   localparam int TOTAL_BITS  = COUNT_BITS + 3 + SAMPLE_BITS;
   localparam int WD_BITS     = SAMPLE_BITS + 1;

   localparam logic [1:0] MODE_OBS = 2'd0;
   localparam logic [1:0] MODE_EOS = 2'd1;
   localparam logic [1:0] MODE_THR = 2'd2;

   localparam logic [2:0] CSR_QMODE   = 3'd0;
   localparam logic [2:0] CSR_MIN_DS  = 3'd1;
   localparam logic [2:0] CSR_MAX_DS  = 3'd2;
   localparam logic [2:0] CSR_MIN_SWD = 3'd3;
   localparam logic [2:0] CSR_MAX_STD = 3'd4;
   localparam logic [2:0] CSR_MIN_STD = 3'd5;
   localparam logic [2:0] CSR_MAX_DA  = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic        obs_we;
      logic        thr_we;
      logic        scan_start;
      logic        scan_step;
      logic        decide;
      logic        emit_load;
      logic        clear_step;
   } cmd_type;

   typedef struct packed {
      logic        scan_last;
      logic        emit_last;
      logic        clear_last;
      logic        out_busy;
   } status_type;

endpackage

@@ sv/pacsf_datapath.sv @@
module pacsf_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  pacsf_pkg::cmd_type                cmd,
   output pacsf_pkg::status_type             status,
   input  logic [5:0]                        req_sample,
   input  logic [2:0]                        req_base_code,
   input  logic [7:0]                        req_quality,
   input  logic                              req_site_enabled,
   input  logic [7:0]                        req_threshold_value,
   input  logic [1:0]                        cfg_quality_mode,
   input  logic signed [16:0]                cfg_min_depth_sample,
   input  logic signed [16:0]                cfg_max_depth_sample,
   input  logic [6:0]                        cfg_min_samples_with_data,
   input  logic signed [24:0]                cfg_max_site_depth,
   input  logic signed [24:0]                cfg_min_site_depth,
   input  logic [2:0]                        cfg_max_distinct_alleles,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [5:0]                        rsp_out_sample,
   output logic [15:0]                       rsp_count_a,
   output logic [15:0]                       rsp_count_c,
   output logic [15:0]                       rsp_count_g,
   output logic [15:0]                       rsp_count_t,
   output logic [6:0]                        rsp_site_keep,
   output logic [23:0]                       rsp_site_depth,
   output logic                              rsp_last_sample
);

   localparam int SB = pacsf_pkg::SAMPLE_BITS;
   localparam int CB = pacsf_pkg::COUNT_BITS;
   localparam int NS = pacsf_pkg::NUM_SAMPLES;
   localparam int DB = pacsf_pkg::SDEPTH_BITS;
   localparam int TB = pacsf_pkg::TOTAL_BITS;
   localparam int WB = pacsf_pkg::WD_BITS;

   // one row per sample holds four counters, thresholds likewise
   logic [4*CB-1:0] cnt_mem [NS];
   logic [4*CB-1:0] cnt_mask_ff;
   logic [NS-1:0]   zap_ff, zap_in;
   logic [31:0]     thr_mem [NS];
   logic [NS-1:0]   thr_valid_ff;

   logic [SB-1:0]   ptr_ff, ptr_in;
   logic            en_ff, en_in;
   logic [TB-1:0]   total_ff, total_in;
   logic [WB-1:0]   wd_ff, wd_in;
   logic [2:0]      diff_ff, diff_in;
   logic [6:0]      keep_ff, keep_in;

   logic            obs_ok;
   logic [SB-1:0]   obs_row;
   logic [1:0]      obs_al;
   logic [4*CB-1:0] row_rd;
   logic [31:0]     thr_row;
   logic [31:0]     thr_wr;
   logic [7:0]      thr_sel;
   logic [CB-1:0]   cur_cnt;

   assign obs_row = req_sample[SB-1:0];
   assign obs_al  = req_base_code[1:0];
   assign row_rd  = cnt_mem[cmd.obs_we ? obs_row : ptr_ff];
   assign thr_row = thr_valid_ff[obs_row] ? thr_mem[obs_row] : 32'd0;

   // whole row is written so untouched alleles keep their old thresholds (zero if never written)
   always_comb begin
      thr_wr = thr_row;
      thr_wr[8*obs_al +: 8] = req_threshold_value;
   end

   always_comb begin
      thr_sel = 8'd0;
      case (cfg_quality_mode)
         2'd0:    thr_sel = 8'd0;
         2'd1:    thr_sel = thr_row[7:0];
         default: thr_sel = thr_row[8*obs_al +: 8];
      endcase
      cur_cnt = row_rd[CB*obs_al +: CB];
      obs_ok  = ({26'd0, req_sample} < 32'(NS)) && !req_base_code[2] && (req_quality >= thr_sel)
                && (cur_cnt != {CB{1'b1}});
   end

   // per-row depth and flags for the scan step
   logic [DB-1:0] row_d;
   logic          row_zap;
   logic [2:0]    row_diff;
   always_comb begin
      row_d = DB'(row_rd[CB-1:0]) + DB'(row_rd[2*CB-1:CB])
            + DB'(row_rd[3*CB-1:2*CB]) + DB'(row_rd[4*CB-1:3*CB]);
      row_diff = 3'(row_rd[CB-1:0] != '0) + 3'(row_rd[2*CB-1:CB] != '0)
               + 3'(row_rd[3*CB-1:2*CB] != '0) + 3'(row_rd[4*CB-1:3*CB] != '0);
      row_zap = 1'b0;
      if (!req_site_enabled && cmd.scan_start) row_zap = 1'b1;
      if (!en_ff) row_zap = 1'b1;
      if (cfg_quality_mode == 2'd0) begin
         if (!cfg_min_depth_sample[16] && $signed({1'b0, row_d}) < 20'(cfg_min_depth_sample))
            row_zap = 1'b1;
         if (!cfg_max_depth_sample[16] && $signed({1'b0, row_d}) > 20'(cfg_max_depth_sample))
            row_zap = 1'b1;
      end
   end

   always_comb begin
      ptr_in   = ptr_ff;
      en_in    = en_ff;
      total_in = total_ff;
      wd_in    = wd_ff;
      diff_in  = diff_ff;
      keep_in  = keep_ff;
      zap_in   = zap_ff;
      if (cmd.scan_start) begin
         ptr_in   = '0;
         en_in    = req_site_enabled;
         total_in = '0;
         wd_in    = '0;
         diff_in  = '0;
      end
      if (cmd.scan_step) begin
         zap_in[ptr_ff] = row_zap;
         if (!row_zap) begin
            total_in = total_ff + TB'(row_d);
            wd_in    = wd_ff + WB'(row_d != '0);
            if (ptr_ff == '0) diff_in = row_diff;
         end
         ptr_in = ptr_ff + SB'(1);
      end
      if (cmd.decide) begin
         keep_in = 7'(en_ff && total_ff != '0);
         if (cfg_min_samples_with_data != '0 && keep_in != '0)
            keep_in = ({1'b0, 7'(wd_ff)} < {1'b0, cfg_min_samples_with_data}) ? 7'd0 : 7'(wd_ff);
         if (!cfg_max_site_depth[24] && 32'(total_ff) > 32'(cfg_max_site_depth[23:0]))
            keep_in = 7'd0;
         if (!cfg_min_site_depth[24] && keep_in != '0)
            keep_in = (32'(total_ff) < 32'(cfg_min_site_depth[23:0])) ? 7'd0 : 7'(wd_ff);
         if (cfg_max_distinct_alleles != '0 && keep_in != '0 && diff_ff > cfg_max_distinct_alleles)
            keep_in = 7'd0;
         ptr_in = '0;
      end
      if (cmd.emit_load) ptr_in = ptr_ff + SB'(1);
      if (cmd.clear_step) ptr_in = ptr_ff + SB'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      en_ff    <= en_in;
      total_ff <= total_in;
      wd_ff    <= wd_in;
      diff_ff  <= diff_in;
      keep_ff  <= keep_in;
      zap_ff   <= zap_in;
      if (cmd.obs_we && obs_ok)
         cnt_mem[obs_row][CB*obs_al +: CB] <= cur_cnt + CB'(1);
      if (cmd.clear_step) cnt_mem[ptr_ff] <= '0;
      if (cmd.thr_we && ({26'd0, req_sample} < 32'(NS)) && !req_base_code[2])
         thr_mem[obs_row] <= thr_wr;
   end

   // thresholds read as zero until their row is first written
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_valid_ff <= '0;
      end else if (cmd.thr_we && ({26'd0, req_sample} < 32'(NS)) && !req_base_code[2]) begin
         thr_valid_ff[obs_row] <= 1'b1;
      end
   end

   // counts must also read as zero from reset, so a clear pass runs after reset
   logic [CB-1:0] oc [4];
   always_comb begin
      for (int a = 0; a < 4; a++) begin
         oc[a] = zap_ff[ptr_ff] ? '0 : row_rd[CB*a +: CB];
      end
   end

   function automatic logic [15:0] sat16(input logic [CB-1:0] v);
      logic [32:0] w;
      w = 33'(v);
      sat16 = (w > 33'd65535) ? 16'hFFFF : w[15:0];
   endfunction

   logic valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_out_sample  <= 6'(ptr_ff);
         rsp_count_a     <= sat16(oc[0]);
         rsp_count_c     <= sat16(oc[1]);
         rsp_count_g     <= sat16(oc[2]);
         rsp_count_t     <= sat16(oc[3]);
         rsp_site_keep   <= keep_ff;
         rsp_site_depth  <= (32'(total_ff) > 32'd16777215) ? 24'hFFFFFF : 24'(total_ff);
         rsp_last_sample <= (32'(ptr_ff) == 32'(NS - 1));
      end
   end

   assign rsp_valid         = valid_ff;
   assign status.scan_last  = (32'(ptr_ff) == 32'(NS - 1));
   assign status.emit_last  = (32'(ptr_ff) == 32'(NS - 1));
   assign status.clear_last = (32'(ptr_ff) == 32'(NS - 1));
   assign status.out_busy   = valid_ff && rsp_stall;

endmodule

@@ sv/pacsf_ctrl.sv @@
module pacsf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  pacsf_pkg::status_type status,
   output pacsf_pkg::cmd_type    cmd
);

   pacsf_pkg::state_type state_ff, state_in;
   logic accept;

   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pacsf_pkg::ST_IDLE:
            if (accept && req_mode == pacsf_pkg::MODE_EOS) state_in = pacsf_pkg::ST_SCAN;
         pacsf_pkg::ST_SCAN:
            if (status.scan_last) state_in = pacsf_pkg::ST_DECIDE;
         pacsf_pkg::ST_DECIDE:
            state_in = pacsf_pkg::ST_EMIT;
         pacsf_pkg::ST_EMIT:
            if (!status.out_busy && status.emit_last) state_in = pacsf_pkg::ST_CLEAR;
         pacsf_pkg::ST_CLEAR:
            if (status.clear_last) state_in = pacsf_pkg::ST_IDLE;
         default:
            state_in = pacsf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         pacsf_pkg::ST_IDLE: begin
            req_stall      = 1'b0;
            cmd.obs_we     = accept && req_mode == pacsf_pkg::MODE_OBS;
            cmd.thr_we     = accept && req_mode == pacsf_pkg::MODE_THR;
            cmd.scan_start = accept && req_mode == pacsf_pkg::MODE_EOS;
         end
         pacsf_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
         pacsf_pkg::ST_DECIDE: cmd.decide = 1'b1;
         pacsf_pkg::ST_EMIT: begin
            cmd.emit_load = !status.out_busy;
         end
         pacsf_pkg::ST_CLEAR:  cmd.clear_step = 1'b1;
         default: cmd = '0;
      endcase
   end

   // reset enters the clear pass so the counters start at zero
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pacsf_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/pileup_allele_count_site_filter_top.sv @@
// Per-site allele counter. Observations and threshold writes are accepted
// while the controller is idle. An end-of-site item walks the counter rows
// once, decides the site, emits NUM_SAMPLES results one per cycle when the
// output is not stalled, then clears the rows; new items are stalled until
// the clear pass ends. After reset a clear pass runs before the first item
// is taken.
`include "assert_macros.svh"
module pileup_allele_count_site_filter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [5:0]  req_sample,
   input  logic [2:0]  req_base_code,
   input  logic [7:0]  req_quality,
   input  logic        req_site_enabled,
   input  logic [7:0]  req_threshold_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_out_sample,
   output logic [15:0] rsp_count_a,
   output logic [15:0] rsp_count_c,
   output logic [15:0] rsp_count_g,
   output logic [15:0] rsp_count_t,
   output logic [6:0]  rsp_site_keep,
   output logic [23:0] rsp_site_depth,
   output logic        rsp_last_sample,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [1:0]         qmode_ff;
   logic signed [16:0] min_ds_ff, max_ds_ff;
   logic [6:0]         min_swd_ff;
   logic signed [24:0] max_std_ff, min_std_ff;
   logic [2:0]         max_da_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         qmode_ff   <= '0;
         min_ds_ff  <= '1;
         max_ds_ff  <= '1;
         min_swd_ff <= '0;
         max_std_ff <= '1;
         min_std_ff <= '1;
         max_da_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            pacsf_pkg::CSR_QMODE:   qmode_ff   <= csr_data[1:0];
            pacsf_pkg::CSR_MIN_DS:  min_ds_ff  <= csr_data[16:0];
            pacsf_pkg::CSR_MAX_DS:  max_ds_ff  <= csr_data[16:0];
            pacsf_pkg::CSR_MIN_SWD: min_swd_ff <= csr_data[6:0];
            pacsf_pkg::CSR_MAX_STD: max_std_ff <= csr_data[24:0];
            pacsf_pkg::CSR_MIN_STD: min_std_ff <= csr_data[24:0];
            pacsf_pkg::CSR_MAX_DA:  max_da_ff  <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   pacsf_pkg::cmd_type    cmd;
   pacsf_pkg::status_type status;

   pacsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .status    (status),
      .cmd       (cmd)
   );

   pacsf_datapath u_dp (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .status                    (status),
      .req_sample                (req_sample),
      .req_base_code             (req_base_code),
      .req_quality               (req_quality),
      .req_site_enabled          (req_site_enabled),
      .req_threshold_value       (req_threshold_value),
      .cfg_quality_mode          (qmode_ff),
      .cfg_min_depth_sample      (min_ds_ff),
      .cfg_max_depth_sample      (max_ds_ff),
      .cfg_min_samples_with_data (min_swd_ff),
      .cfg_max_site_depth        (max_std_ff),
      .cfg_min_site_depth        (min_std_ff),
      .cfg_max_distinct_alleles  (max_da_ff),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_out_sample            (rsp_out_sample),
      .rsp_count_a               (rsp_count_a),
      .rsp_count_c               (rsp_count_c),
      .rsp_count_g               (rsp_count_g),
      .rsp_count_t               (rsp_count_t),
      .rsp_site_keep             (rsp_site_keep),
      .rsp_site_depth            (rsp_site_depth),
      .rsp_last_sample           (rsp_last_sample)
   );

   `ASSERT_NEXT(a_hold_while_stalled, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_IMPLY(a_one_cmd, clock, reset, 1'b1, $onehot0({cmd.obs_we, cmd.thr_we, cmd.scan_start,
      cmd.scan_step, cmd.decide, cmd.emit_load, cmd.clear_step}))
   `ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit_load, rsp_valid)

endmodule
